// ===== rtl/ecol_pkg.sv =====
// Shared widths, status codes and the sideband type for the disc collision pipeline.
// No dependencies; every other file imports this package.
package ecol_pkg;

  localparam int FW        = 24;  // position and velocity field width
  localparam int MW        = 16;  // mass and radius width
  localparam int DW        = 25;  // centre and velocity difference width
  localparam int WW        = 17;  // doubled mass, mass sum, radius sum
  localparam int DXW       = 18;  // centre difference while in contact
  localparam int MAGW      = 17;  // magnitude of the contact difference
  localparam int SQW       = 49;  // one squared centre difference
  localparam int D2W       = 50;  // squared centre distance
  localparam int RS2W      = 34;  // squared radius sum
  localparam int PDW       = 43;  // one term of the dot product
  localparam int DOTW      = 44;  // dot product
  localparam int DMAGW     = 43;  // dot product magnitude
  localparam int PRODW     = 60;  // |c * dot|
  localparam int HALFW     = 30;  // half of PRODW for the split multiply
  localparam int PPW       = 47;  // HALFW x WW partial product
  localparam int NUM_W     = 77;  // dividend
  localparam int DEN_W     = 51;  // divisor d2 * msum
  localparam int QW        = 26;  // quotient bits kept
  localparam int LANES     = 4;   // ax, ay, bx, by
  localparam int FRONT_STAGES = 7;
  localparam int DIV_BITS  = 26;
  localparam int LATENCY   = FRONT_STAGES + DIV_BITS + 2;

  localparam logic signed [FW-1:0] SAT_HI = 24'sh7FFFFF;
  localparam logic signed [FW-1:0] SAT_LO = 24'sh800000;

  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_RESOLVED   = 2'd1,
    ST_COINCIDENT = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  // Data that rides alongside the arithmetic to the final stage
  typedef struct packed {
    logic [LANES-1:0][FW-1:0] vel;
    logic [LANES-1:0]         neg;
    logic                     contact;
    logic                     coincident;
    logic                     mzero;
  } side_t;

endpackage

// ===== rtl/disc_elastic_collision_top.sv =====
// Two-disc elastic collision resolver, fully pipelined.
// From input transfer to result a disc pair passes seven front stages, 27 divider stages
// (overflow check and one quotient bit each) and the output register.
// Throughput one disc pair per cycle; a stalled output holds the whole pipeline.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
// Depends on ecol_pkg, ecol_front and ecol_div.
module disc_elastic_collision_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ecol_pkg::FW-1:0]         in_pos_a_x,
  input  logic [ecol_pkg::FW-1:0]         in_pos_a_y,
  input  logic [ecol_pkg::FW-1:0]         in_vel_a_x,
  input  logic [ecol_pkg::FW-1:0]         in_vel_a_y,
  input  logic [ecol_pkg::MW-1:0]         in_mass_a,
  input  logic [ecol_pkg::MW-1:0]         in_radius_a,
  input  logic [ecol_pkg::FW-1:0]         in_pos_b_x,
  input  logic [ecol_pkg::FW-1:0]         in_pos_b_y,
  input  logic [ecol_pkg::FW-1:0]         in_vel_b_x,
  input  logic [ecol_pkg::FW-1:0]         in_vel_b_y,
  input  logic [ecol_pkg::MW-1:0]         in_mass_b,
  input  logic [ecol_pkg::MW-1:0]         in_radius_b,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ecol_pkg::FW-1:0]  out_new_vel_a_x,
  output logic signed [ecol_pkg::FW-1:0]  out_new_vel_a_y,
  output logic signed [ecol_pkg::FW-1:0]  out_new_vel_b_x,
  output logic signed [ecol_pkg::FW-1:0]  out_new_vel_b_y,
  output logic [1:0]                      out_contact_status
);
  import ecol_pkg::*;

  localparam int RW = QW + 2;

  logic [LATENCY-1:0]          vld_r, vld_nxt;
  logic                        en;
  logic [LANES-1:0][NUM_W-1:0] f_num;
  logic [DEN_W-1:0]            f_den;
  side_t                       f_side, d_side;
  logic [LANES-1:0][QW-1:0]    d_quot;
  logic [LANES-1:0]            d_ovf;

  logic [LANES-1:0][FW-1:0]    res_r, res_nxt;
  status_t                     status_r, status_nxt;
  logic [QW-1:0]               chg;
  logic signed [RW-1:0]        v_ext, c_ext, sum;
  logic                        sat_any;
  logic                        sub;

  // advance every stage unless the result is held
  assign en       = !(vld_r[LATENCY-1] && out_stall);
  assign in_stall = !en;

  always_comb begin
    vld_nxt = {vld_r[LATENCY-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  ecol_front u_front (
    .clk      (clk),
    .en       (en),
    .pos_a_x  (in_pos_a_x),
    .pos_a_y  (in_pos_a_y),
    .vel_a_x  (in_vel_a_x),
    .vel_a_y  (in_vel_a_y),
    .mass_a   (in_mass_a),
    .radius_a (in_radius_a),
    .pos_b_x  (in_pos_b_x),
    .pos_b_y  (in_pos_b_y),
    .vel_b_x  (in_vel_b_x),
    .vel_b_y  (in_vel_b_y),
    .mass_b   (in_mass_b),
    .radius_b (in_radius_b),
    .num      (f_num),
    .den      (f_den),
    .side     (f_side)
  );

  ecol_div u_div (
    .clk      (clk),
    .en       (en),
    .num      (f_num),
    .den      (f_den),
    .side_in  (f_side),
    .quot     (d_quot),
    .ovf      (d_ovf),
    .side_out (d_side)
  );

  // apply the signed change, saturate and pick the status
  always_comb begin
    sat_any = 1'b0;
    chg     = '0;
    v_ext   = '0;
    c_ext   = '0;
    sum     = '0;
    sub     = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      chg   = d_ovf[l] ? {QW{1'b1}} : d_quot[l];
      v_ext = $signed({{(RW-FW){d_side.vel[l][FW-1]}}, d_side.vel[l]});
      c_ext = $signed({2'b00, chg});
      // disc A loses the change, disc B gains it
      sub   = l[1] ? d_side.neg[l] : !d_side.neg[l];
      sum   = sub ? (v_ext - c_ext) : (v_ext + c_ext);
      if (sum > RW'(SAT_HI)) begin
        res_nxt[l] = SAT_HI;
        sat_any    = 1'b1;
      end else if (sum < RW'(SAT_LO)) begin
        res_nxt[l] = SAT_LO;
        sat_any    = 1'b1;
      end else begin
        res_nxt[l] = sum[FW-1:0];
      end
    end
    if (!d_side.contact) begin
      status_nxt = ST_NONE;
      res_nxt    = d_side.vel;
    end else if (d_side.coincident) begin
      status_nxt = ST_COINCIDENT;
      res_nxt    = d_side.vel;
    end else if (d_side.mzero) begin
      status_nxt = ST_RESOLVED;
      res_nxt    = d_side.vel;
    end else begin
      status_nxt = sat_any ? ST_SATURATED : ST_RESOLVED;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r    <= res_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid          = vld_r[LATENCY-1];
  assign out_new_vel_a_x    = res_r[0];
  assign out_new_vel_a_y    = res_r[1];
  assign out_new_vel_b_x    = res_r[2];
  assign out_new_vel_b_y    = res_r[3];
  assign out_contact_status = status_r;

`ifndef ASSERT_OFF
  a_sat_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_contact_status == ST_SATURATED) |->
      (out_new_vel_a_x == SAT_HI || out_new_vel_a_x == SAT_LO ||
       out_new_vel_a_y == SAT_HI || out_new_vel_a_y == SAT_LO ||
       out_new_vel_b_x == SAT_HI || out_new_vel_b_x == SAT_LO ||
       out_new_vel_b_y == SAT_HI || out_new_vel_b_y == SAT_LO))
    else $error("saturated status without a saturated component");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output is free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

// ===== rtl/ecol_front.sv =====
// Front pipeline: differences, squares, contact test, dot product and dividend build.
// Seven register stages; depends on ecol_pkg.
module ecol_front (
  input  logic                                        clk,
  input  logic                                        en,
  input  logic [ecol_pkg::FW-1:0]                     pos_a_x,
  input  logic [ecol_pkg::FW-1:0]                     pos_a_y,
  input  logic [ecol_pkg::FW-1:0]                     vel_a_x,
  input  logic [ecol_pkg::FW-1:0]                     vel_a_y,
  input  logic [ecol_pkg::MW-1:0]                     mass_a,
  input  logic [ecol_pkg::MW-1:0]                     radius_a,
  input  logic [ecol_pkg::FW-1:0]                     pos_b_x,
  input  logic [ecol_pkg::FW-1:0]                     pos_b_y,
  input  logic [ecol_pkg::FW-1:0]                     vel_b_x,
  input  logic [ecol_pkg::FW-1:0]                     vel_b_y,
  input  logic [ecol_pkg::MW-1:0]                     mass_b,
  input  logic [ecol_pkg::MW-1:0]                     radius_b,
  output logic [ecol_pkg::LANES-1:0][ecol_pkg::NUM_W-1:0] num,
  output logic [ecol_pkg::DEN_W-1:0]                  den,
  output ecol_pkg::side_t                             side
);
  import ecol_pkg::*;

  // stage 1
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_dvx_r, s1_dvy_r;
  logic [WW-1:0]        s1_rs_r, s1_msum_r, s1_wa_r, s1_wb_r;
  side_t                s1_side_r;
  // stage 2
  logic [SQW-1:0]        s2_dx2_r, s2_dy2_r;
  logic [RS2W-1:0]       s2_rs2_r;
  logic signed [PDW-1:0] s2_pdx_r, s2_pdy_r;
  logic [MAGW-1:0]       s2_dxm_r, s2_dym_r;
  logic                  s2_dxn_r, s2_dyn_r;
  logic [WW-1:0]         s2_msum_r, s2_wa_r, s2_wb_r;
  side_t                 s2_side_r;
  // stage 3
  logic [RS2W-1:0]        s3_d2_r;
  logic signed [DOTW-1:0] s3_dot_r;
  logic [MAGW-1:0]        s3_dxm_r, s3_dym_r;
  logic                   s3_dxn_r, s3_dyn_r;
  logic [WW-1:0]          s3_msum_r, s3_wa_r, s3_wb_r;
  side_t                  s3_side_r;
  // stage 4
  logic [DMAGW-1:0] s4_dotm_r;
  logic [DEN_W-1:0] s4_den_r;
  logic [MAGW-1:0]  s4_dxm_r, s4_dym_r;
  logic [WW-1:0]    s4_wa_r, s4_wb_r;
  side_t            s4_side_r;
  // stage 5
  logic [PRODW-1:0] s5_nx_r, s5_ny_r;
  logic [DEN_W-1:0] s5_den_r;
  logic [WW-1:0]    s5_wa_r, s5_wb_r;
  side_t            s5_side_r;
  // stage 6
  logic [LANES-1:0][PPW-1:0] s6_lo_r, s6_hi_r;
  logic [DEN_W-1:0]          s6_den_r;
  side_t                     s6_side_r;
  // stage 7
  logic [LANES-1:0][NUM_W-1:0] s7_num_r;
  logic [DEN_W-1:0]            s7_den_r;
  side_t                       s7_side_r;

  logic signed [DW-1:0]   s1_dx_nxt, s1_dy_nxt, s1_dvx_nxt, s1_dvy_nxt;
  side_t                  s1_side_nxt;
  logic signed [DXW-1:0]  dx18, dy18;
  logic [DXW-1:0]         dxa, dya;
  logic signed [2*DW-1:0] dx2_full, dy2_full;
  logic signed [PDW-1:0]  s2_pdx_nxt, s2_pdy_nxt;
  logic [D2W-1:0]         d2_full;
  logic signed [DOTW-1:0] s3_dot_nxt;
  logic [DOTW-1:0]        dot_abs;
  side_t                  s3_side_nxt, s4_side_nxt;
  logic [LANES-1:0][PPW-1:0] s6_lo_nxt, s6_hi_nxt;
  logic [LANES-1:0][NUM_W-1:0] s7_num_nxt;
  logic [PRODW-1:0]       lane_n;
  logic [WW-1:0]          lane_w;

  // stage 1: differences, radius sum, weights
  always_comb begin
    s1_dx_nxt  = $signed({pos_a_x[FW-1], pos_a_x}) - $signed({pos_b_x[FW-1], pos_b_x});
    s1_dy_nxt  = $signed({pos_a_y[FW-1], pos_a_y}) - $signed({pos_b_y[FW-1], pos_b_y});
    s1_dvx_nxt = $signed({vel_a_x[FW-1], vel_a_x}) - $signed({vel_b_x[FW-1], vel_b_x});
    s1_dvy_nxt = $signed({vel_a_y[FW-1], vel_a_y}) - $signed({vel_b_y[FW-1], vel_b_y});
    s1_side_nxt            = '0;
    s1_side_nxt.vel[0]     = vel_a_x;
    s1_side_nxt.vel[1]     = vel_a_y;
    s1_side_nxt.vel[2]     = vel_b_x;
    s1_side_nxt.vel[3]     = vel_b_y;
    s1_side_nxt.mzero      = (mass_a == '0) && (mass_b == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r   <= s1_dx_nxt;
      s1_dy_r   <= s1_dy_nxt;
      s1_dvx_r  <= s1_dvx_nxt;
      s1_dvy_r  <= s1_dvy_nxt;
      s1_rs_r   <= {1'b0, radius_a} + {1'b0, radius_b};
      s1_msum_r <= {1'b0, mass_a} + {1'b0, mass_b};
      s1_wa_r   <= {mass_a, 1'b0};
      s1_wb_r   <= {mass_b, 1'b0};
      s1_side_r <= s1_side_nxt;
    end
  end

  // stage 2: squares, dot terms, contact-range magnitudes
  always_comb begin
    dx18       = s1_dx_r[DXW-1:0];
    dy18       = s1_dy_r[DXW-1:0];
    dxa        = dx18[DXW-1] ? (~dx18 + 1'b1) : dx18;
    dya        = dy18[DXW-1] ? (~dy18 + 1'b1) : dy18;
    dx2_full   = (2*DW)'(s1_dx_r) * (2*DW)'(s1_dx_r);
    dy2_full   = (2*DW)'(s1_dy_r) * (2*DW)'(s1_dy_r);
    s2_pdx_nxt = PDW'(s1_dvx_r) * PDW'(dx18);
    s2_pdy_nxt = PDW'(s1_dvy_r) * PDW'(dy18);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dx2_r  <= dx2_full[SQW-1:0];
      s2_dy2_r  <= dy2_full[SQW-1:0];
      s2_rs2_r  <= RS2W'(s1_rs_r) * RS2W'(s1_rs_r);
      s2_pdx_r  <= s2_pdx_nxt;
      s2_pdy_r  <= s2_pdy_nxt;
      s2_dxm_r  <= dxa[MAGW-1:0];
      s2_dym_r  <= dya[MAGW-1:0];
      s2_dxn_r  <= dx18[DXW-1];
      s2_dyn_r  <= dy18[DXW-1];
      s2_msum_r <= s1_msum_r;
      s2_wa_r   <= s1_wa_r;
      s2_wb_r   <= s1_wb_r;
      s2_side_r <= s1_side_r;
    end
  end

  // stage 3: distance, contact test, dot product
  always_comb begin
    d2_full    = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};
    s3_dot_nxt = DOTW'(s2_pdx_r) + DOTW'(s2_pdy_r);
    s3_side_nxt            = s2_side_r;
    s3_side_nxt.contact    = d2_full < {(D2W-RS2W)'(0), s2_rs2_r};
    s3_side_nxt.coincident = (d2_full == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d2_r   <= d2_full[RS2W-1:0];
      s3_dot_r  <= s3_dot_nxt;
      s3_dxm_r  <= s2_dxm_r;
      s3_dym_r  <= s2_dym_r;
      s3_dxn_r  <= s2_dxn_r;
      s3_dyn_r  <= s2_dyn_r;
      s3_msum_r <= s2_msum_r;
      s3_wa_r   <= s2_wa_r;
      s3_wb_r   <= s2_wb_r;
      s3_side_r <= s3_side_nxt;
    end
  end

  // stage 4: dot magnitude, product signs, divisor
  always_comb begin
    dot_abs = s3_dot_r[DOTW-1] ? (~s3_dot_r + 1'b1) : s3_dot_r;
    s4_side_nxt        = s3_side_r;
    s4_side_nxt.neg[0] = s3_dxn_r ^ s3_dot_r[DOTW-1];
    s4_side_nxt.neg[1] = s3_dyn_r ^ s3_dot_r[DOTW-1];
    s4_side_nxt.neg[2] = s3_dxn_r ^ s3_dot_r[DOTW-1];
    s4_side_nxt.neg[3] = s3_dyn_r ^ s3_dot_r[DOTW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_dotm_r <= dot_abs[DMAGW-1:0];
      s4_den_r  <= DEN_W'(s3_d2_r) * DEN_W'(s3_msum_r);
      s4_dxm_r  <= s3_dxm_r;
      s4_dym_r  <= s3_dym_r;
      s4_wa_r   <= s3_wa_r;
      s4_wb_r   <= s3_wb_r;
      s4_side_r <= s4_side_nxt;
    end
  end

  // stage 5: component times dot
  always_ff @(posedge clk) begin
    if (en) begin
      s5_nx_r   <= PRODW'(s4_dxm_r) * PRODW'(s4_dotm_r);
      s5_ny_r   <= PRODW'(s4_dym_r) * PRODW'(s4_dotm_r);
      s5_den_r  <= s4_den_r;
      s5_wa_r   <= s4_wa_r;
      s5_wb_r   <= s4_wb_r;
      s5_side_r <= s4_side_r;
    end
  end

  // stage 6: split weight multiply per lane
  always_comb begin
    lane_n = '0;
    lane_w = '0;
    for (int l = 0; l < LANES; l++) begin
      lane_n = l[0] ? s5_ny_r : s5_nx_r;
      lane_w = l[1] ? s5_wa_r : s5_wb_r;
      s6_lo_nxt[l] = PPW'(lane_n[HALFW-1:0]) * PPW'(lane_w);
      s6_hi_nxt[l] = PPW'(lane_n[PRODW-1:HALFW]) * PPW'(lane_w);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_lo_r   <= s6_lo_nxt;
      s6_hi_r   <= s6_hi_nxt;
      s6_den_r  <= s5_den_r;
      s6_side_r <= s5_side_r;
    end
  end

  // stage 7: recombine partial products into the dividend
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s7_num_nxt[l] = (NUM_W'(s6_hi_r[l]) << HALFW) + NUM_W'(s6_lo_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_num_r  <= s7_num_nxt;
      s7_den_r  <= s6_den_r;
      s7_side_r <= s6_side_r;
    end
  end

  assign num  = s7_num_r;
  assign den  = s7_den_r;
  assign side = s7_side_r;

endmodule

// ===== rtl/ecol_div.sv =====
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit a stage.
// An overflow stage flags quotients too large to keep; depends on ecol_pkg.
module ecol_div (
  input  logic                                            clk,
  input  logic                                            en,
  input  logic [ecol_pkg::LANES-1:0][ecol_pkg::NUM_W-1:0] num,
  input  logic [ecol_pkg::DEN_W-1:0]                      den,
  input  ecol_pkg::side_t                                 side_in,
  output logic [ecol_pkg::LANES-1:0][ecol_pkg::QW-1:0]    quot,
  output logic [ecol_pkg::LANES-1:0]                      ovf,
  output ecol_pkg::side_t                                 side_out
);
  import ecol_pkg::*;

  logic [LANES-1:0][NUM_W-1:0] rem_r  [DIV_BITS+1];
  logic [DEN_W-1:0]            den_r  [DIV_BITS+1];
  logic [LANES-1:0][QW-1:0]    q_r    [DIV_BITS+1];
  logic [LANES-1:0]            ovf_r  [DIV_BITS+1];
  side_t                       side_r [DIV_BITS+1];

  logic [LANES-1:0] ovf_nxt;

  // flag quotients that need more than QW bits
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ovf_nxt[l] = num[l] >= (NUM_W'(den) << QW);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      ovf_r[0]  <= ovf_nxt;
      side_r[0] <= side_in;
    end
  end

  // one trial subtract per stage, most significant bit first
  for (genvar j = 1; j <= DIV_BITS; j++) begin : g_step
    localparam int SH = DIV_BITS - j;
    logic [NUM_W-1:0]            trial;
    logic [LANES-1:0][NUM_W-1:0] rem_nxt;
    logic [LANES-1:0][QW-1:0]    q_nxt;

    always_comb begin
      trial = NUM_W'(den_r[j-1]) << SH;
      for (int l = 0; l < LANES; l++) begin
        q_nxt[l] = q_r[j-1][l];
        if (rem_r[j-1][l] >= trial) begin
          rem_nxt[l]   = rem_r[j-1][l] - trial;
          q_nxt[l][SH] = 1'b1;
        end else begin
          rem_nxt[l]   = rem_r[j-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_r[j-1];
        q_r[j]    <= q_nxt;
        ovf_r[j]  <= ovf_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign quot     = q_r[DIV_BITS];
  assign ovf      = ovf_r[DIV_BITS];
  assign side_out = side_r[DIV_BITS];

endmodule

// ===== test/disc_elastic_collision_top_tb.sv =====
// Self-checking testbench for disc_elastic_collision_top: streams disc pairs through the
// pipeline and checks every result against a bit-exact collision predictor.
// Depends on ecol_pkg and the RTL of the collision pipeline.
module disc_elastic_collision_top_tb;
  import ecol_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam longint VEL_MAX = 8388607;
  localparam longint VEL_MIN = -8388608;

  typedef struct {
    logic [FW-1:0] pax, pay, vax, vay;
    logic [MW-1:0] ma, ra;
    logic [FW-1:0] pbx, pby, vbx, vby;
    logic [MW-1:0] mb, rb;
    bit            wait_drain;
  } disc_pair_t;

  typedef struct {
    logic signed [FW-1:0] nax, nay, nbx, nby;
    logic [1:0]           status;
  } bounce_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  logic signed [FW-1:0] out_new_vel_a_x, out_new_vel_a_y, out_new_vel_b_x, out_new_vel_b_y;
  logic [1:0] out_contact_status;
  disc_pair_t cur;

  disc_pair_t pending_pairs[$];
  bounce_t    bounce_queue[$];
  int errors = 0;
  int n_sent = 0;
  int cycle = 0;

  disc_elastic_collision_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_a_x(cur.pax), .in_pos_a_y(cur.pay),
    .in_vel_a_x(cur.vax), .in_vel_a_y(cur.vay),
    .in_mass_a(cur.ma), .in_radius_a(cur.ra),
    .in_pos_b_x(cur.pbx), .in_pos_b_y(cur.pby),
    .in_vel_b_x(cur.vbx), .in_vel_b_y(cur.vby),
    .in_mass_b(cur.mb), .in_radius_b(cur.rb),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_new_vel_a_x(out_new_vel_a_x), .out_new_vel_a_y(out_new_vel_a_y),
    .out_new_vel_b_x(out_new_vel_b_x), .out_new_vel_b_y(out_new_vel_b_y),
    .out_contact_status(out_contact_status)
  );

  // Truncated n*w/(d2*msum), exact in 128 bits
  function automatic longint impulse_share(longint n, longint d2, longint w, longint msum);
    bit [127:0] mag;
    bit [127:0] q;
    mag = (n < 0) ? 128'(-n) : 128'(n);
    q = (mag * 128'(w)) / (128'(d2) * 128'(msum));
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [FW-1:0] clamp_vel(longint v, inout bit sat);
    if (v > VEL_MAX) begin
      sat = 1;
      return SAT_HI;
    end
    if (v < VEL_MIN) begin
      sat = 1;
      return SAT_LO;
    end
    return v[FW-1:0];
  endfunction

  function automatic bounce_t resolve_pair(disc_pair_t p);
    longint dx, dy, d2, rs, dot, nx, ny, msum, vax, vay, vbx, vby;
    bit sat;
    bounce_t r;
    vax = longint'($signed(p.vax));
    vay = longint'($signed(p.vay));
    vbx = longint'($signed(p.vbx));
    vby = longint'($signed(p.vby));
    dx = longint'($signed(p.pax)) - longint'($signed(p.pbx));
    dy = longint'($signed(p.pay)) - longint'($signed(p.pby));
    d2 = dx * dx + dy * dy;
    rs = longint'(p.ra) + longint'(p.rb);
    msum = longint'(p.ma) + longint'(p.mb);
    sat = 0;
    r.nax = p.vax;
    r.nay = p.vay;
    r.nbx = p.vbx;
    r.nby = p.vby;
    if (d2 >= rs * rs) begin
      r.status = ST_NONE;
    end else if (d2 == 0) begin
      r.status = ST_COINCIDENT;
    end else begin
      r.status = ST_RESOLVED;
      if (msum != 0) begin
        dot = (vax - vbx) * dx + (vay - vby) * dy;
        nx = dx * dot;
        ny = dy * dot;
        r.nax = clamp_vel(vax - impulse_share(nx, d2, 2 * longint'(p.mb), msum), sat);
        r.nay = clamp_vel(vay - impulse_share(ny, d2, 2 * longint'(p.mb), msum), sat);
        r.nbx = clamp_vel(vbx + impulse_share(nx, d2, 2 * longint'(p.ma), msum), sat);
        r.nby = clamp_vel(vby + impulse_share(ny, d2, 2 * longint'(p.ma), msum), sat);
        if (sat) r.status = ST_SATURATED;
      end
    end
    return r;
  endfunction

  function automatic disc_pair_t make_pair(longint pax, longint pay, longint vax, longint vay,
                                           int ma, int ra, longint pbx, longint pby,
                                           longint vbx, longint vby, int mb, int rb);
    disc_pair_t p;
    p.pax = pax[FW-1:0]; p.pay = pay[FW-1:0]; p.vax = vax[FW-1:0]; p.vay = vay[FW-1:0];
    p.pbx = pbx[FW-1:0]; p.pby = pby[FW-1:0]; p.vbx = vbx[FW-1:0]; p.vby = vby[FW-1:0];
    p.ma = ma[MW-1:0]; p.ra = ra[MW-1:0]; p.mb = mb[MW-1:0]; p.rb = rb[MW-1:0];
    p.wait_drain = 0;
    return p;
  endfunction

  function automatic longint rand_vel();
    case ($urandom_range(0, 3))
      0: return longint'($signed(24'($urandom)));
      1: return $urandom_range(0, 1) ? VEL_MAX - $urandom_range(0, 4000)
                                     : VEL_MIN + $urandom_range(0, 4000);
      default: return longint'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Pair placed so the discs touch most of the time
  function automatic disc_pair_t touching_pair();
    longint pax, pay, rs, dx, dy;
    int ra, rb, ma, mb;
    ra = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 2048);
    rb = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 2048);
    ma = $urandom_range(0, 4) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 300);
    mb = $urandom_range(0, 4) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 300);
    rs = ra + rb;
    dx = longint'($urandom_range(0, 2 * rs)) - rs;
    dy = longint'($urandom_range(0, 2 * rs)) - rs;
    pax = longint'($signed(24'($urandom)));
    pay = longint'($signed(24'($urandom)));
    return make_pair(pax, pay, rand_vel(), rand_vel(), ma, ra, pax - dx, pay - dy,
                     rand_vel(), rand_vel(), mb, rb);
  endfunction

  function automatic disc_pair_t noise_pair();
    return make_pair(longint'($urandom), longint'($urandom), longint'($urandom),
                     longint'($urandom), $urandom_range(1, 65535), $urandom_range(0, 65535),
                     longint'($urandom), longint'($urandom), longint'($urandom),
                     longint'($urandom), $urandom_range(1, 65535), $urandom_range(0, 65535));
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("disc_elastic_collision_top_tb: errors");
      $finish;
    end
  end

  // Driver: bursts and gaps, payload held while stalled
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        bounce_queue.push_back(resolve_pair(cur));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 0;
          gap_left--;
        end else if (pending_pairs.size() > 0 &&
                     !(pending_pairs[0].wait_drain && bounce_queue.size() > 0)) begin
          cur <= pending_pairs.pop_front();
          in_valid <= 1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: stall pattern with one long hold-off, compare each transfer
  int holdoff_left = 0;
  bit holdoff_done = 0;
  always @(posedge clk) begin
    bounce_t e;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bounce_queue.size() == 0) begin
          $error("unexpected result status %0d", out_contact_status);
          errors++;
        end else begin
          e = bounce_queue.pop_front();
          if (out_new_vel_a_x !== e.nax) begin
            $error("new_vel_a_x exp %0d got %0d", e.nax, out_new_vel_a_x);
            errors++;
          end
          if (out_new_vel_a_y !== e.nay) begin
            $error("new_vel_a_y exp %0d got %0d", e.nay, out_new_vel_a_y);
            errors++;
          end
          if (out_new_vel_b_x !== e.nbx) begin
            $error("new_vel_b_x exp %0d got %0d", e.nbx, out_new_vel_b_x);
            errors++;
          end
          if (out_new_vel_b_y !== e.nby) begin
            $error("new_vel_b_y exp %0d got %0d", e.nby, out_new_vel_b_y);
            errors++;
          end
          if (out_contact_status !== e.status) begin
            $error("contact_status exp %0d got %0d", e.status, out_contact_status);
            errors++;
          end
        end
      end
      if (!holdoff_done && n_sent >= 200) begin
        holdoff_done = 1;
        holdoff_left = 300;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1;
      end else begin
        case ((cycle / 400) % 3)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  initial begin
    disc_pair_t p;
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    cur = make_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0);

    // Directed: zero radii on one spot, coincident, head-on, extremes, saturation
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0));
    pending_pairs.push_back(make_pair(0, 0, 100, -50, 1, 256, 0, 0, -7, 9, 1, 256));
    pending_pairs.push_back(make_pair(-256, 0, 512, 0, 10, 300, 256, 0, -512, 0, 10, 300));
    pending_pairs.push_back(make_pair(0, -256, 0, 512, 1, 300, 0, 256, 0, -512, 65535, 300));
    pending_pairs.push_back(make_pair(VEL_MAX, VEL_MAX, 1000, 0, 65535, 65535,
                                      VEL_MAX - 300, VEL_MAX - 400, 0, 0, 65535, 65535));
    pending_pairs.push_back(make_pair(VEL_MIN, VEL_MIN, 0, 0, 1, 65535,
                                      VEL_MIN + 1, VEL_MIN, 0, 0, 1, 65535));
    pending_pairs.push_back(make_pair(VEL_MAX, 0, 0, 0, 1, 65535, VEL_MIN, 0, 0, 0, 1, 65535));
    pending_pairs.push_back(make_pair(0, 0, VEL_MAX, VEL_MAX, 65535, 100,
                                      1, 1, VEL_MIN, VEL_MIN, 65535, 100));
    pending_pairs.push_back(make_pair(0, 0, VEL_MIN, VEL_MAX, 1, 100,
                                      -1, 0, VEL_MAX, VEL_MIN, 65535, 100));
    pending_pairs.push_back(make_pair(0, 0, VEL_MAX, 0, 65535, 50, 60, 0, VEL_MIN, 0, 1, 50));
    pending_pairs.push_back(make_pair(0, 0, 5, 5, 7, 100, 200, 0, 0, 0, 7, 100));
    pending_pairs.push_back(make_pair(0, 0, 5, 5, 7, 100, 199, 0, 0, 0, 7, 100));
    pending_pairs.push_back(make_pair(123, -77, -3, 4, 2, 0, 123, -77, 1, 1, 3, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 65535, 65535, 0, 0, 0, 0, 65535, 65535));
    pending_pairs.push_back(make_pair(1000, 1000, -300, 200, 40, 512, 1300, 700, 250, -100,
                                      9, 512));
    for (int i = 0; i < 6; i++) pending_pairs.push_back(noise_pair());

    // Random: mostly touching pairs, some noise, two drain points
    for (int i = 0; i < 640; i++) begin
      p = ($urandom_range(0, 9) < 8) ? touching_pair() : noise_pair();
      if (i == 0 || i == 420) p.wait_drain = 1;
      pending_pairs.push_back(p);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1;

    wait (pending_pairs.size() == 0);
    @(posedge clk);
    while (in_valid || bounce_queue.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (bounce_queue.size() > 0) begin
      $error("%0d results never arrived", bounce_queue.size());
      errors++;
    end
    if (errors == 0) begin
      $display("disc_elastic_collision_top_tb: clean");
    end else begin
      $display("disc_elastic_collision_top_tb: errors");
    end
    $finish;
  end

endmodule
